>>> rtl/afc_pkg.sv
// shared constants and types for the box frustum cull block
package afc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned FLR_W  = PROD_W - FRAC_W;
  // four summed Q32.16 terms plus headroom for the negated w compare
  localparam int unsigned ACC_W  = FLR_W + 3;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned OP_W   = 2;

  localparam logic [OP_W-1:0] OP_WR_VP    = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_MODEL = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST     = 2'd2;
  // unused code, the transaction is dropped
  localparam logic [OP_W-1:0] OP_RSVD     = 2'd3;

  localparam logic MAT_MODEL = 1'b0;
  localparam logic MAT_VP    = 1'b1;

  typedef struct packed {
    logic             en;
    logic             sel;
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] data;
  } afc_wr_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_add;
  } afc_mac_ctrl_t;

endpackage

>>> rtl/afc_if.sv
// handshake channels for the box frustum cull block
interface afc_in_if;
  logic                                valid;
  logic                                ready;
  logic        [afc_pkg::OP_W-1:0]     operation;
  logic        [afc_pkg::IDX_W-1:0]    matrix_index;
  logic signed [afc_pkg::DATA_W-1:0]   matrix_value;
  logic signed [afc_pkg::DATA_W-1:0]   box_min_x;
  logic signed [afc_pkg::DATA_W-1:0]   box_min_y;
  logic signed [afc_pkg::DATA_W-1:0]   box_min_z;
  logic signed [afc_pkg::DATA_W-1:0]   box_max_x;
  logic signed [afc_pkg::DATA_W-1:0]   box_max_y;
  logic signed [afc_pkg::DATA_W-1:0]   box_max_z;

  modport source (output valid, operation, matrix_index, matrix_value, box_min_x, box_min_y,
                  box_min_z, box_max_x, box_max_y, box_max_z, input ready);
  modport sink (input valid, operation, matrix_index, matrix_value, box_min_x, box_min_y,
                box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface afc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

>>> rtl/afc_regfile.sv
// model and view-projection matrix storage, one write and one read port
module afc_regfile (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  afc_pkg::afc_wr_t                   wr_i,
  input  logic                               rd_sel_i,
  input  logic        [afc_pkg::IDX_W-1:0]   rd_idx_i,
  output logic signed [afc_pkg::DATA_W-1:0]  rd_data_o
);

  localparam int unsigned Depth = 2 ** afc_pkg::IDX_W;

  logic [afc_pkg::DATA_W-1:0] model_q [Depth];
  logic [afc_pkg::DATA_W-1:0] vp_q    [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        model_q[i] <= '0;
        vp_q[i]    <= '0;
      end
    end else if (wr_i.en) begin
      if (wr_i.sel == afc_pkg::MAT_VP) begin
        vp_q[wr_i.idx] <= wr_i.data;
      end else begin
        model_q[wr_i.idx] <= wr_i.data;
      end
    end
  end

  assign rd_data_o = (rd_sel_i == afc_pkg::MAT_VP) ? $signed(vp_q[rd_idx_i])
                                                   : $signed(model_q[rd_idx_i]);

endmodule

>>> rtl/afc_mac.sv
// shared multiply-accumulate unit with floor rounding of each product to q32.16
module afc_mac (
  input  logic                               clk_i,
  input  afc_pkg::afc_mac_ctrl_t             ctrl_i,
  input  logic signed [afc_pkg::DATA_W-1:0]  coef_i,
  input  logic signed [afc_pkg::DATA_W-1:0]  opnd_i,
  output logic signed [afc_pkg::ACC_W-1:0]   sum_o
);

  logic signed [afc_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [afc_pkg::FLR_W-1:0]  prod_flr;
  logic signed [afc_pkg::ACC_W-1:0]  acc_q;

  assign prod_d   = coef_i * opnd_i;
  // arithmetic drop of the fraction bits rounds toward minus infinity
  assign prod_flr = prod_q[afc_pkg::PROD_W-1:afc_pkg::FRAC_W];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_add) begin
      acc_q <= acc_q + afc_pkg::ACC_W'(prod_flr);
    end
  end

  // last column: coefficient times 1.0 is the coefficient itself
  assign sum_o = acc_q + afc_pkg::ACC_W'(prod_flr) + afc_pkg::ACC_W'(coef_i);

endmodule

>>> rtl/aabb_frustum_cull.sv
// top level: sequencer driving the shared mac over eight corners and two matrices
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | operation, matrix_index, matrix_value, box min/max xyz
//  out_o   | out | valid / ready | visible
//
// a matrix write gives no result and leaves the block ready
// a box test runs 8 corners x 7 rows, four matrix columns each, through the single
// shared multiplier, then a compare flush state and an output state
// in_i.ready is high only while idle; the result waits in an output register
// reset clears both matrices to zero and the control state
module aabb_frustum_cull (
  input  logic      clk_i,
  input  logic      rst_ni,
  afc_in_if.sink    in_i,
  afc_out_if.source out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam int unsigned DW = afc_pkg::DATA_W;
  localparam int unsigned AW = afc_pkg::ACC_W;

  logic [1:0] state_q, state_d;
  logic [2:0] k_q;
  logic       ph_q;
  logic [1:0] rc_q, c_q, row;

  logic signed [DW-1:0] lo_q [3];
  logic signed [DW-1:0] hi_q [3];
  logic signed [DW-1:0] world_q [3];
  logic signed [AW-1:0] w_q, cmp_val_q, sum;
  logic [1:0]           cmp_row_q;
  logic                 pend_q;
  logic [5:0]           all_out_q;
  logic                 out_valid_q, visible_q;

  logic                   in_acc, run_end;
  logic signed [DW-1:0]   coef, opnd, sat_sum;
  afc_pkg::afc_wr_t       wr;
  afc_pkg::afc_mac_ctrl_t mac_ctrl;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign wr.en   = in_acc && ((in_i.operation == afc_pkg::OP_WR_VP) ||
                              (in_i.operation == afc_pkg::OP_WR_MODEL));
  assign wr.sel  = (in_i.operation == afc_pkg::OP_WR_VP) ? afc_pkg::MAT_VP
                                                          : afc_pkg::MAT_MODEL;
  assign wr.idx  = in_i.matrix_index;
  assign wr.data = in_i.matrix_value;

  // clip rows run w first, then x, y, z
  assign row = ph_q ? (rc_q - 2'd1) : rc_q;

  afc_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_sel_i  (ph_q),
    .rd_idx_i  ({c_q, row}),
    .rd_data_o (coef)
  );

  always_comb begin
    unique case (c_q)
      2'd0:    opnd = ph_q ? world_q[0] : (k_q[0] ? hi_q[0] : lo_q[0]);
      2'd1:    opnd = ph_q ? world_q[1] : (k_q[1] ? hi_q[1] : lo_q[1]);
      2'd2:    opnd = ph_q ? world_q[2] : (k_q[2] ? hi_q[2] : lo_q[2]);
      default: opnd = '0;
    endcase
  end

  always_comb begin
    mac_ctrl = '0;
    if (state_q == ST_RUN) begin
      mac_ctrl.mul_en  = (c_q != 2'd3);
      mac_ctrl.acc_clr = (c_q == 2'd0);
      mac_ctrl.acc_add = (c_q == 2'd1) || (c_q == 2'd2);
    end
  end

  afc_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .coef_i (coef),
    .opnd_i (opnd),
    .sum_o  (sum)
  );

  always_comb begin
    if (sum[AW-1:DW-1] != '0 && sum[AW-1:DW-1] != '1) begin
      sat_sum = sum[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      sat_sum = sum[DW-1:0];
    end
  end

  assign run_end = (c_q == 2'd3) && ph_q && (rc_q == 2'd3) && (k_q == 3'd7);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && in_i.operation == afc_pkg::OP_TEST) state_d = ST_RUN;
      ST_RUN:  if (run_end) state_d = ST_CMP;
      ST_CMP:  state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      ph_q        <= 1'b0;
      rc_q        <= '0;
      c_q         <= '0;
      pend_q      <= 1'b0;
      all_out_q   <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new result may replace one taken in the same cycle
      if (state_q == ST_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_IDLE) begin
        k_q       <= '0;
        ph_q      <= 1'b0;
        rc_q      <= '0;
        c_q       <= '0;
        pend_q    <= 1'b0;
        all_out_q <= '1;
      end
      if (pend_q) begin
        all_out_q[{cmp_row_q, 1'b0}] <= all_out_q[{cmp_row_q, 1'b0}] & (cmp_val_q < -w_q);
        all_out_q[{cmp_row_q, 1'b1}] <= all_out_q[{cmp_row_q, 1'b1}] & (cmp_val_q > w_q);
        pend_q <= 1'b0;
      end
      if (state_q == ST_RUN) begin
        c_q <= c_q + 2'd1;
        if (c_q == 2'd3) begin
          if (!ph_q) begin
            if (rc_q == 2'd2) begin
              ph_q <= 1'b1;
              rc_q <= '0;
            end else begin
              rc_q <= rc_q + 2'd1;
            end
          end else begin
            if (row != 2'd3) begin
              pend_q <= 1'b1;
            end
            if (rc_q == 2'd3) begin
              ph_q <= 1'b0;
              rc_q <= '0;
              k_q  <= k_q + 3'd1;
            end else begin
              rc_q <= rc_q + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.operation == afc_pkg::OP_TEST) begin
      lo_q[0] <= in_i.box_min_x;
      lo_q[1] <= in_i.box_min_y;
      lo_q[2] <= in_i.box_min_z;
      hi_q[0] <= in_i.box_max_x;
      hi_q[1] <= in_i.box_max_y;
      hi_q[2] <= in_i.box_max_z;
    end
    if (state_q == ST_RUN && c_q == 2'd3) begin
      if (!ph_q) begin
        world_q[rc_q] <= sat_sum;
      end else if (row == 2'd3) begin
        w_q <= sum;
      end else begin
        cmp_val_q <= sum;
        cmp_row_q <= row;
      end
    end
    if (state_q == ST_OUT && (!out_valid_q || out_o.ready)) begin
      visible_q <= ~|all_out_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.visible = visible_q;

endmodule

>>> rtl/afc_checker.sv
// port-level checks for the box frustum cull block and its bind
module afc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [afc_pkg::OP_W-1:0]   in_op_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_visible_i
);

  // a box test keeps the block busy
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == afc_pkg::OP_TEST |=> !in_ready_i)
    else $error("block ready right after a box test transaction");

  // a matrix write leaves the block ready
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
    (in_op_i == afc_pkg::OP_WR_VP || in_op_i == afc_pkg::OP_WR_MODEL) |=> in_ready_i)
    else $error("block busy after a matrix write transaction");

  // a result only shows up at the end of a busy box test
  a_no_result_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared with no box test");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_visible_i))
    else $error("stalled result dropped or changed");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_op_i       (in_i.operation),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_visible_i (out_o.visible)
);
